### src/amdp_pkg.sv
package amdp_pkg;

  localparam int unsigned DefCountWidth = 32;
  localparam int unsigned NumChan       = 4;
  localparam int unsigned ThrWidth      = 16;

  // Channel positions in the level and peak rings.
  localparam int unsigned ChMag = 0;
  localparam int unsigned ChX   = 1;
  localparam int unsigned ChY   = 2;
  localparam int unsigned ChZ   = 3;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic               any_change;
    logic signed [15:0] held_x;
    logic signed [15:0] held_y;
    logic signed [15:0] held_z;
    logic [15:0]        held_magnitude;
    logic [14:0]        peak_x;
    logic [14:0]        peak_y;
    logic [14:0]        peak_z;
    logic [15:0]        peak_magnitude;
    logic [31:0]        sample_count;
  } out_item_t;

  // Tracker state handed from the channel unit to the top level.
  typedef struct packed {
    logic                         any_change;
    logic [NumChan-1:0][16:0]     held;
    logic [NumChan-1:0][15:0]     peak;
  } trk_state_t;

  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StRoot,
    StChan,
    StDone
  } state_e;

  // Axis peaks are reported in 15 bits; a full-scale negative input saturates.
  function automatic logic [14:0] sat_peak(logic [15:0] p);
    return p[15] ? 15'h7FFF : p[14:0];
  endfunction

endpackage

### src/amdp_sqsum.sv
module amdp_sqsum import amdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  in_item_t    item_i,
  output logic        done_o,
  output logic [31:0] sum_o
);

  localparam int unsigned DigitSteps = 8;
  localparam int unsigned CntWidth   = $clog2(DigitSteps);

  logic [15:0]         ax_q, ay_q, az_q;
  logic [15:0]         dx_q, dy_q, dz_q;
  logic [31:0]         acc_q, acc_d;
  logic [CntWidth-1:0] cnt_q;
  logic                busy_q, done_q;
  logic                last_step;

  function automatic logic [15:0] abs16(logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic [17:0] digit_mul(logic [1:0] d, logic [15:0] a);
    return 18'(d) * 18'(a);
  endfunction

  // Each step takes the next two-bit digit of every magnitude, most significant first.
  always_comb begin
    acc_d = {acc_q[29:0], 2'b00}
          + 32'(digit_mul(dx_q[15:14], ax_q))
          + 32'(digit_mul(dy_q[15:14], ay_q))
          + 32'(digit_mul(dz_q[15:14], az_q));
  end

  assign last_step = busy_q && (cnt_q == CntWidth'(DigitSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntWidth'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ax_q  <= abs16(item_i.accel_x);
      ay_q  <= abs16(item_i.accel_y);
      az_q  <= abs16(item_i.accel_z);
      dx_q  <= abs16(item_i.accel_x);
      dy_q  <= abs16(item_i.accel_y);
      dz_q  <= abs16(item_i.accel_z);
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      dx_q  <= {dx_q[13:0], 2'b00};
      dy_q  <= {dy_q[13:0], 2'b00};
      dz_q  <= {dz_q[13:0], 2'b00};
    end
  end

  assign done_o = done_q;
  assign sum_o  = acc_q;

endmodule

### src/amdp_isqrt.sv
module amdp_isqrt import amdp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] n_i,
  output logic        done_o,
  output logic [15:0] root_o
);

  localparam int unsigned RootSteps = 16;
  localparam int unsigned CntWidth  = $clog2(RootSteps);

  logic [31:0]         n_q;
  logic [16:0]         rem_q, rem_d;
  logic [15:0]         root_q, root_d;
  logic [18:0]         rem_sh, trial, diff;
  logic                ge;
  logic [CntWidth-1:0] cnt_q;
  logic                busy_q, done_q;
  logic                last_step;

  // One root bit per step: bring down two radicand bits and try root*4+1.
  always_comb begin
    rem_sh = {rem_q, n_q[31:30]};
    trial  = {1'b0, root_q, 2'b01};
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
    rem_d  = ge ? diff[16:0] : rem_sh[16:0];
    root_d = {root_q[14:0], ge};
  end

  assign last_step = busy_q && (cnt_q == CntWidth'(RootSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntWidth'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= n_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= {n_q[29:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### src/amdp_chan.sv
module amdp_chan import amdp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [NumChan-1:0][16:0] levels_i,
  input  logic [ThrWidth-1:0]      thr_i,
  output logic                     done_o,
  output trk_state_t               trk_o
);

  localparam int unsigned CntWidth = $clog2(NumChan);

  logic signed [16:0]  lvl_q  [NumChan];
  logic signed [16:0]  held_q [NumChan];
  logic [15:0]         peak_q [NumChan];
  logic                seen_q, any_q;
  logic [CntWidth-1:0] cnt_q;
  logic                busy_q, done_q;
  logic                last_step;

  logic signed [17:0]  diff;
  logic [17:0]         mag;
  logic [16:0]         abs_lvl;
  logic                first, replace;
  logic signed [16:0]  held_new;
  logic [15:0]         peak_new;

  // The rings rotate by one channel per step, so the channel under work sits at the head.
  always_comb begin
    first    = !seen_q;
    diff     = {lvl_q[0][16], lvl_q[0]} - {held_q[0][16], held_q[0]};
    mag      = diff[17] ? 18'(-diff) : 18'(diff);
    abs_lvl  = lvl_q[0][16] ? 17'(-lvl_q[0]) : 17'(lvl_q[0]);
    replace  = first || (mag >= 18'(thr_i));
    held_new = replace ? lvl_q[0] : held_q[0];
    peak_new = (replace && (first || (abs_lvl[15:0] > peak_q[0]))) ? abs_lvl[15:0]
                                                                   : peak_q[0];
  end

  assign last_step = busy_q && (cnt_q == CntWidth'(NumChan - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      seen_q <= 1'b0;
      any_q  <= 1'b0;
      for (int i = 0; i < NumChan; i++) begin
        held_q[i] <= '0;
        peak_q[i] <= '0;
      end
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        any_q  <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntWidth'(1);
        any_q <= any_q | replace;
        for (int i = 0; i < NumChan - 1; i++) begin
          held_q[i] <= held_q[i+1];
          peak_q[i] <= peak_q[i+1];
        end
        held_q[NumChan-1] <= held_new;
        peak_q[NumChan-1] <= peak_new;
        if (last_step) begin
          busy_q <= 1'b0;
          seen_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < NumChan; i++) begin
        lvl_q[i] <= levels_i[i];
      end
    end else if (busy_q) begin
      for (int i = 0; i < NumChan - 1; i++) begin
        lvl_q[i] <= lvl_q[i+1];
      end
      lvl_q[NumChan-1] <= lvl_q[0];
    end
  end

  always_comb begin
    trk_o.any_change = any_q;
    for (int i = 0; i < NumChan; i++) begin
      trk_o.held[i] = held_q[i];
      trk_o.peak[i] = peak_q[i];
    end
  end

  assign done_o = done_q;

endmodule

### src/accel_magnitude_deadband_peak_tracker_unit.sv
// Processing: each accepted sample passes through 8 two-bit digit steps for the sum
// of squares, 16 steps of the bit-serial square root and 4 channel steps.
// Flow: a sample is taken only when idle, after the previous one is done; a finished
// result waits in the output register while the next sample is taken and processed.
// Reset: asynchronous, active low; clears held levels, peaks, the first-sample flag,
// the sample counter and the change threshold.
module accel_magnitude_deadband_peak_tracker_unit import amdp_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = DefCountWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ThrWidth-1:0] cfg_data_i
);

  state_e                   state_q, state_d;
  in_item_t                 item_q;
  logic [ThrWidth-1:0]      thr_q;
  logic [COUNT_WIDTH-1:0]   count_q;
  out_item_t                out_q;
  logic                     out_valid_q;

  logic                     in_accept, sq_start, root_start, chan_start, out_load;
  logic                     sq_done, root_done, chan_done;
  logic [31:0]              sum;
  logic [15:0]              root;
  logic [NumChan-1:0][16:0] levels;
  trk_state_t               trk;

  amdp_sqsum u_sqsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .item_i  (in_data_i),
    .done_o  (sq_done),
    .sum_o   (sum)
  );

  amdp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .n_i     (sum),
    .done_o  (root_done),
    .root_o  (root)
  );

  always_comb begin
    levels        = '0;
    levels[ChMag] = {1'b0, root};
    levels[ChX]   = {item_q.accel_x[15], item_q.accel_x};
    levels[ChY]   = {item_q.accel_y[15], item_q.accel_y};
    levels[ChZ]   = {item_q.accel_z[15], item_q.accel_z};
  end

  amdp_chan u_chan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (chan_start),
    .levels_i (levels),
    .thr_i    (thr_q),
    .done_o   (chan_done),
    .trk_o    (trk)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StSquare;
        end
      end
      StSquare: begin
        if (sq_done) begin
          state_d = StRoot;
        end
      end
      StRoot: begin
        if (root_done) begin
          state_d = StChan;
        end
      end
      StChan: begin
        if (chan_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    root_start = 1'b0;
    chan_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      StIdle:   in_ready_o = 1'b1;
      StSquare: root_start = sq_done;
      StRoot:   chan_start = root_done;
      StChan:   ;
      StDone:   out_load   = !out_valid_q || out_ready_i;
      default:  ;
    endcase
  end

  assign in_accept   = in_valid_i && in_ready_o;
  assign sq_start    = in_accept;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      thr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
      if (in_accept) begin
        count_q <= count_q + COUNT_WIDTH'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (out_load) begin
      out_q.any_change     <= trk.any_change;
      out_q.held_x         <= trk.held[ChX][15:0];
      out_q.held_y         <= trk.held[ChY][15:0];
      out_q.held_z         <= trk.held[ChZ][15:0];
      out_q.held_magnitude <= trk.held[ChMag][15:0];
      out_q.peak_x         <= sat_peak(trk.peak[ChX]);
      out_q.peak_y         <= sat_peak(trk.peak[ChY]);
      out_q.peak_z         <= sat_peak(trk.peak[ChZ]);
      out_q.peak_magnitude <= trk.peak[ChMag];
      out_q.sample_count   <= 32'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Each unit finishes only while the sequencer waits for it.
  a_sq_done_in_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == StSquare)
    else $error("squaring unit finished outside its phase");

  a_root_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> state_q == StRoot)
    else $error("square root unit finished outside its phase");

  a_chan_done_in_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_done |-> state_q == StChan)
    else $error("channel unit finished outside its phase");

  // A new result appears only after the channel pass of a sample has completed.
  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone))
    else $error("result became valid without a finished sample");

endmodule
